/* src/cursor_sequence_buffer_unit_defines.svh */
// Assertion macros shared by the RTL.
`ifndef CURSOR_SEQUENCE_BUFFER_UNIT_DEFINES_SVH
`define CURSOR_SEQUENCE_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CSBU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSBU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/csbu_pkg.sv */
`timescale 1ns / 1ps

package csbu_pkg;

   localparam int CAPACITY  = 64;
   localparam int WORD_BITS = 32;
   localparam int IDX_BITS  = $clog2(CAPACITY);
   localparam int CNT_BITS  = IDX_BITS + 1;

   localparam logic [2:0] OP_START   = 3'd0;
   localparam logic [2:0] OP_ADVANCE = 3'd1;
   localparam logic [2:0] OP_INSERT  = 3'd2;
   localparam logic [2:0] OP_ATTACH  = 3'd3;
   localparam logic [2:0] OP_REMOVE  = 3'd4;
   localparam logic [2:0] OP_READ    = 3'd5;

   localparam logic [1:0] STATUS_DONE       = 2'd0;
   localparam logic [1:0] STATUS_FULL       = 2'd1;
   localparam logic [1:0] STATUS_NO_CURRENT = 2'd2;

   typedef logic [CNT_BITS-1:0]  count_type;
   typedef logic [WORD_BITS-1:0] word_type;

endpackage

/* src/cursor_sequence_buffer_unit.sv */
`timescale 1ns / 1ps

// Ordered buffer of up to 64 words with a cursor, driven one request at a time.
// A request is taken when start is high and busy is low; busy then stays high
// until the single result has been shown on the rsp_ ports for one cycle with
// rsp_valid high. The receiver cannot stall, so the result must be captured in
// that cycle. All entries live in one single-port-write, registered-read memory
// and a shift moves each entry with a read and then a write. Start, advance,
// read and rejected requests move no entries; insert, attach and remove move
// up to 63 entries each.
module cursor_sequence_buffer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_opcode,
   input  logic [csbu_pkg::WORD_BITS-1:0]    req_entry_value,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [csbu_pkg::CNT_BITS-1:0]     rsp_item_count,
   output logic                              rsp_has_current,
   output logic [csbu_pkg::CNT_BITS-1:0]     rsp_cursor_position,
   output logic [csbu_pkg::WORD_BITS-1:0]    rsp_current_value
);

`include "cursor_sequence_buffer_unit_defines.svh"

   localparam int CW = csbu_pkg::CNT_BITS;
   localparam int IW = csbu_pkg::IDX_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_UP_RD = 3'd1;
   localparam logic [2:0] S_UP_WR = 3'd2;
   localparam logic [2:0] S_DN_RD = 3'd3;
   localparam logic [2:0] S_DN_WR = 3'd4;
   localparam logic [2:0] S_PUT   = 3'd5;
   localparam logic [2:0] S_FETCH = 3'd6;
   localparam logic [2:0] S_RESP  = 3'd7;

   logic [2:0]               state_ff, state_in;
   csbu_pkg::count_type      count_ff, count_in;
   csbu_pkg::count_type      cursor_ff, cursor_in;
   csbu_pkg::count_type      idx_ff, idx_in;
   logic [1:0]               status_ff, status_in;
   csbu_pkg::word_type       val_ff, val_in;
   csbu_pkg::word_type       rdata_ff;

   csbu_pkg::word_type       mem [csbu_pkg::CAPACITY];

   logic                     rd_en;
   logic [IW-1:0]            rd_addr;
   logic                     wr_en;
   logic [IW-1:0]            wr_addr;
   csbu_pkg::word_type       wr_data;

   logic                     accept;
   logic                     has_cur;
   logic                     full;
   csbu_pkg::count_type      idx_dec;
   csbu_pkg::count_type      idx_inc;

   assign accept  = start && (state_ff == S_IDLE);
   assign has_cur = cursor_ff < count_ff;
   assign full    = count_ff == CW'(csbu_pkg::CAPACITY);
   assign idx_dec = idx_ff - CW'(1);
   assign idx_inc = idx_ff + CW'(1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      val_in    = val_ff;
      rd_en     = 1'b0;
      rd_addr   = cursor_ff[IW-1:0];
      wr_en     = 1'b0;
      wr_addr   = idx_ff[IW-1:0];
      wr_data   = rdata_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = csbu_pkg::STATUS_DONE;
               val_in    = req_entry_value;
               state_in  = S_FETCH;
               case (req_opcode)
                  csbu_pkg::OP_START: begin
                     cursor_in = '0;
                  end
                  csbu_pkg::OP_ADVANCE: begin
                     if (has_cur) begin
                        cursor_in = cursor_ff + CW'(1);
                     end else begin
                        status_in = csbu_pkg::STATUS_NO_CURRENT;
                     end
                  end
                  csbu_pkg::OP_INSERT: begin
                     if (full) begin
                        status_in = csbu_pkg::STATUS_FULL;
                     end else begin
                        cursor_in = has_cur ? cursor_ff : '0;
                        idx_in    = count_ff;
                        state_in  = S_UP_RD;
                     end
                  end
                  csbu_pkg::OP_ATTACH: begin
                     if (full) begin
                        status_in = csbu_pkg::STATUS_FULL;
                     end else begin
                        cursor_in = has_cur ? cursor_ff + CW'(1) : count_ff;
                        idx_in    = count_ff;
                        state_in  = S_UP_RD;
                     end
                  end
                  csbu_pkg::OP_REMOVE: begin
                     if (has_cur) begin
                        idx_in   = cursor_ff;
                        state_in = S_DN_RD;
                     end else begin
                        status_in = csbu_pkg::STATUS_NO_CURRENT;
                     end
                  end
                  csbu_pkg::OP_READ: begin
                     if (!has_cur) begin
                        status_in = csbu_pkg::STATUS_NO_CURRENT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // open a gap at the cursor: entry idx-1 moves to idx
         S_UP_RD: begin
            if (idx_ff > cursor_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_dec[IW-1:0];
               state_in = S_UP_WR;
            end else begin
               state_in = S_PUT;
            end
         end
         S_UP_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_dec;
            state_in = S_UP_RD;
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = cursor_ff[IW-1:0];
            wr_data  = val_ff;
            count_in = count_ff + CW'(1);
            state_in = S_FETCH;
         end
         // close the gap: entry idx+1 moves to idx
         S_DN_RD: begin
            if (idx_inc < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_inc[IW-1:0];
               state_in = S_DN_WR;
            end else begin
               // cursor < old count, so it never exceeds the new count
               count_in = count_ff - CW'(1);
               state_in = S_FETCH;
            end
         end
         S_DN_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_inc;
            state_in = S_DN_RD;
         end
         S_FETCH: begin
            rd_en    = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
      idx_ff    <= idx_in;
      status_ff <= status_in;
      val_ff    <= val_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign busy                = state_ff != S_IDLE;
   assign rsp_valid           = state_ff == S_RESP;
   assign rsp_status          = status_ff;
   assign rsp_item_count      = count_ff;
   assign rsp_has_current     = has_cur;
   assign rsp_cursor_position = cursor_ff;
   assign rsp_current_value   = has_cur ? rdata_ff : '0;

   `CSBU_ASSERT_IMPLY(a_cursor_in_range, clock, reset, 1'b1, cursor_ff <= count_ff,
                      "cursor beyond count")
   `CSBU_ASSERT_IMPLY(a_count_in_range, clock, reset, 1'b1,
                      count_ff <= CW'(csbu_pkg::CAPACITY), "count beyond capacity")
   `CSBU_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
                     "not busy after accepting a request")
   `CSBU_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid && !busy,
                     "result strobe longer than one cycle")
   `CSBU_ASSERT_NEXT(a_put_grows, clock, reset, state_ff == S_PUT,
                     count_ff == $past(count_ff) + CW'(1), "count did not grow on store")

endmodule
